### hw/rtl/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define CHK_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

// Check a property on every rising edge, reset cycles included.
`define CHK_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: property failed");

`endif

### hw/rtl/sip_tre_pkg.sv
// Shared types, codes and constants of the SIP transaction retry engine.
`timescale 1ns / 1ps

package sip_tre_pkg;

  localparam int TICK_W         = 24;
  localparam int RETRY_W        = 5;
  localparam int TIMER_BITS_DEF = 24;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_ADDR_W     = 5;
  localparam int CFG_DATA_W     = 32;
  localparam int REG_IDX_W      = 3;

  localparam logic [RETRY_W-1:0] RETRY_SAT = 5'd31;

  // Reset values of the configuration registers
  localparam logic [TICK_W-1:0]  RETRY_MIN_RST       = 24'd500;
  localparam logic [TICK_W-1:0]  RETRY_MAX_RST       = 24'd4000;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST     = 5'd7;
  localparam logic [TICK_W-1:0]  REQ_TIMEOUT_RST     = 24'd32000;
  localparam logic [TICK_W-1:0]  CLEANUP_RST         = 24'd5000;
  localparam logic [TICK_W-1:0]  ACK_WAIT_RST        = 24'd32000;
  localparam logic [TICK_W-1:0]  INVITE_EXPIRY_RST   = 24'd180000;
  localparam logic               INVITE_MODE_RST     = 1'b0;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RETRY_MIN     = 3'd0,
    REG_RETRY_MAX     = 3'd1,
    REG_MAX_RETRIES   = 3'd2,
    REG_REQ_TIMEOUT   = 3'd3,
    REG_CLEANUP       = 3'd4,
    REG_ACK_WAIT      = 3'd5,
    REG_INVITE_EXPIRY = 3'd6,
    REG_INVITE_MODE   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_RESPONSE = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_TRYING     = 4'd1,
    PH_PROCEEDING = 4'd2,
    PH_CANCELLING = 4'd3,
    PH_COMPLETED  = 4'd4,
    PH_SUCCESS    = 4'd5,
    PH_TIMEOUT    = 4'd6,
    PH_RETRIES    = 4'd7,
    PH_TRANSPORT  = 4'd8,
    PH_CANCELLED  = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    SEND_NONE    = 2'd0,
    SEND_REQUEST = 2'd1,
    SEND_CANCEL  = 2'd2,
    SEND_ACK     = 2'd3
  } send_t;

  typedef struct packed {
    logic [TICK_W-1:0]  retry_min;
    logic [TICK_W-1:0]  retry_max;
    logic [RETRY_W-1:0] max_retries;
    logic [TICK_W-1:0]  req_timeout;
    logic [TICK_W-1:0]  cleanup;
    logic [TICK_W-1:0]  ack_wait;
    logic [TICK_W-1:0]  invite_expiry;
    logic               invite_mode;
  } cfg_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    op_t  op;
    logic link_ok;
    logic final_resp;
    logic cseq_is_cancel;
    logic cseq_matches;
  } req_t;

  typedef struct packed {
    phase_t             txn_state;
    send_t              send_kind;
    logic               pass_response;
    logic               report_failure;
    logic               finished;
    logic               refused;
    logic [RETRY_W-1:0] retries_done;
  } res_t;

endpackage

### hw/rtl/sip_transaction_retry_engine_top.sv
// SIP client transaction retry engine, top level.
// An event passes the front stage, the middle queue, the engine's request register
// and the result queue before it shows on the result ports. The engine loads a request
// only after executing the last (the backoff interval is registered from the retry count between them).
// Reset (rst, synchronous): queues empty, phase idle, timers stopped,
// registers at their default values.
`timescale 1ns / 1ps

module sip_transaction_retry_engine_top import sip_tre_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            op,
  input  logic                  link_ok,
  input  logic [2:0]            status_class,
  input  logic                  cseq_is_cancel,
  input  logic                  cseq_matches,
  output logic                  empty,
  input  logic                  pop,
  output logic [3:0]            txn_state,
  output logic [1:0]            send_kind,
  output logic                  pass_response,
  output logic                  report_failure,
  output logic                  finished,
  output logic                  refused,
  output logic [RETRY_W-1:0]    retries_done,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  req_t front_req;
  req_t mid_head;
  logic front_push;
  logic mid_full;
  logic mid_empty;
  logic mid_pop;
  res_t back_res;
  res_t out_head;
  logic res_push;
  logic res_full;

  sip_tre_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sip_tre_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .op             (op),
    .link_ok        (link_ok),
    .status_class   (status_class),
    .cseq_is_cancel (cseq_is_cancel),
    .cseq_matches   (cseq_matches),
    .q_push         (front_push),
    .q_data         (front_req),
    .q_full         (mid_full)
  );

  // Decoupling queue between front and back
  sip_tre_fifo #(
    .WIDTH ($bits(req_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_req),
    .full  (mid_full),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_head)
  );

  sip_tre_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_head   (mid_head),
    .q_valid  (!mid_empty),
    .q_pop    (mid_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  // Result queue toward the consumer
  sip_tre_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .rdata (out_head)
  );

  assign txn_state      = out_head.txn_state;
  assign send_kind      = out_head.send_kind;
  assign pass_response  = out_head.pass_response;
  assign report_failure = out_head.report_failure;
  assign finished       = out_head.finished;
  assign refused        = out_head.refused;
  assign retries_done   = out_head.retries_done;

endmodule

### hw/rtl/sip_tre_fifo.sv
// Small register queue used between the engine stages.
`timescale 1ns / 1ps

module sip_tre_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

### hw/rtl/sip_tre_regs.sv
// APB configuration register file of the retry engine.
`timescale 1ns / 1ps

module sip_tre_regs import sip_tre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_min     <= RETRY_MIN_RST;
      cfg.retry_max     <= RETRY_MAX_RST;
      cfg.max_retries   <= MAX_RETRIES_RST;
      cfg.req_timeout   <= REQ_TIMEOUT_RST;
      cfg.cleanup       <= CLEANUP_RST;
      cfg.ack_wait      <= ACK_WAIT_RST;
      cfg.invite_expiry <= INVITE_EXPIRY_RST;
      cfg.invite_mode   <= INVITE_MODE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_RETRY_MIN:     cfg.retry_min     <= pwdata[TICK_W-1:0];
        REG_RETRY_MAX:     cfg.retry_max     <= pwdata[TICK_W-1:0];
        REG_MAX_RETRIES:   cfg.max_retries   <= pwdata[RETRY_W-1:0];
        REG_REQ_TIMEOUT:   cfg.req_timeout   <= pwdata[TICK_W-1:0];
        REG_CLEANUP:       cfg.cleanup       <= pwdata[TICK_W-1:0];
        REG_ACK_WAIT:      cfg.ack_wait      <= pwdata[TICK_W-1:0];
        REG_INVITE_EXPIRY: cfg.invite_expiry <= pwdata[TICK_W-1:0];
        REG_INVITE_MODE:   cfg.invite_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (idx)
      REG_RETRY_MIN:     prdata = CFG_DATA_W'(cfg.retry_min);
      REG_RETRY_MAX:     prdata = CFG_DATA_W'(cfg.retry_max);
      REG_MAX_RETRIES:   prdata = CFG_DATA_W'(cfg.max_retries);
      REG_REQ_TIMEOUT:   prdata = CFG_DATA_W'(cfg.req_timeout);
      REG_CLEANUP:       prdata = CFG_DATA_W'(cfg.cleanup);
      REG_ACK_WAIT:      prdata = CFG_DATA_W'(cfg.ack_wait);
      REG_INVITE_EXPIRY: prdata = CFG_DATA_W'(cfg.invite_expiry);
      REG_INVITE_MODE:   prdata = CFG_DATA_W'(cfg.invite_mode);
      default:           prdata = '0;
    endcase
  end

endmodule

### hw/rtl/sip_tre_front.sv
// Front end: accepts events, classifies them and queues them for the engine.
`timescale 1ns / 1ps

module sip_tre_front import sip_tre_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op,
  input  logic       link_ok,
  input  logic [2:0] status_class,
  input  logic       cseq_is_cancel,
  input  logic       cseq_matches,
  output logic       q_push,
  output req_t       q_data,
  input  logic       q_full
);

  logic stage_valid;
  logic take;

  // Stage drains whenever the queue has room
  assign q_push = stage_valid;
  assign full   = stage_valid && q_full;
  assign take   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (!q_full) begin
      stage_valid <= 1'b0;
    end
  end

  // Classify: anything but a provisional class counts as final
  always_ff @(posedge clk) begin
    if (take) begin
      q_data.op             <= op_t'(op);
      q_data.link_ok        <= link_ok;
      q_data.final_resp     <= (status_class != 3'd1);
      q_data.cseq_is_cancel <= cseq_is_cancel;
      q_data.cseq_matches   <= cseq_matches;
    end
  end

endmodule

### hw/rtl/sip_tre_back.sv
// Back end: transaction state, retry and completion timers, send commands.
`timescale 1ns / 1ps

module sip_tre_back import sip_tre_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  req_t q_head,
  input  logic q_valid,
  output logic q_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam int IV_W = TICK_W + 31;

  req_t                  req;
  logic                  req_valid;
  logic                  exec;

  phase_t                phase, phase_next;
  logic [RETRY_W-1:0]    retry_count, count_next, count_sat;
  logic [TIMER_BITS-1:0] retry_left, rleft_next;
  logic                  retry_armed, rarmed_next;
  logic [TIMER_BITS-1:0] finish_left, fleft_next;
  logic                  finish_armed, farmed_next;

  logic [IV_W-1:0]       iv_wide;
  logic [TICK_W-1:0]     iv_reg;

  logic                  live, cfire, rfire, term;
  phase_t                term_to;
  send_t                 send;
  logic                  pass, fin, refuse;

  // Load a request only into an empty stage, so the interval register
  // always reflects the retry count left by the previous request
  assign q_pop    = q_valid && !req_valid;
  assign exec     = req_valid && !res_full;
  assign res_push = exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (q_pop) begin
      req_valid <= 1'b1;
    end else if (exec) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req <= q_head;
    end
  end

  // Precompute the next backoff interval: min << (count + 1), capped at max
  assign count_sat = (retry_count == RETRY_SAT) ? retry_count : retry_count + RETRY_W'(1);
  assign iv_wide   = IV_W'(cfg.retry_min) << count_sat;

  always_ff @(posedge clk) begin
    iv_reg <= (iv_wide > IV_W'(cfg.retry_max)) ? cfg.retry_max : iv_wide[TICK_W-1:0];
  end

  // Next state and result of the current request
  always_comb begin
    phase_next  = phase;
    count_next  = retry_count;
    rleft_next  = retry_left;
    rarmed_next = retry_armed;
    fleft_next  = finish_left;
    farmed_next = finish_armed;
    send        = SEND_NONE;
    pass        = 1'b0;
    fin         = 1'b0;
    refuse      = 1'b0;
    term        = 1'b0;
    term_to     = PH_TRANSPORT;
    live        = (phase >= PH_TRYING) && (phase <= PH_COMPLETED);
    cfire       = finish_armed && (finish_left <= TIMER_BITS'(1));
    rfire       = retry_armed && (retry_left <= TIMER_BITS'(1));

    case (req.op)
      OP_START: begin
        if (phase != PH_IDLE) begin
          refuse = 1'b1;
        end else begin
          phase_next  = PH_TRYING;
          count_next  = '0;
          rleft_next  = TIMER_BITS'(cfg.retry_min);
          rarmed_next = 1'b1;
          fleft_next  = TIMER_BITS'(cfg.req_timeout);
          farmed_next = 1'b1;
          send        = SEND_REQUEST;
          if (!req.link_ok) begin
            term = 1'b1;
          end
        end
      end
      OP_CANCEL: begin
        if (phase == PH_IDLE || phase >= PH_CANCELLING) begin
          refuse = 1'b1;
        end else begin
          send = SEND_CANCEL;
          if (!req.link_ok) begin
            term = 1'b1;
          end else begin
            phase_next  = PH_CANCELLING;
            count_next  = '0;
            rleft_next  = TIMER_BITS'(cfg.retry_min);
            rarmed_next = 1'b1;
          end
        end
      end
      OP_RESPONSE: begin
        if (live) begin
          if (req.cseq_is_cancel) begin
            term    = 1'b1;
            term_to = PH_CANCELLED;
          end else if (req.cseq_matches) begin
            if (!req.final_resp) begin
              // Provisional: ignored once completed
              if (phase != PH_COMPLETED) begin
                pass        = 1'b1;
                phase_next  = PH_PROCEEDING;
                count_next  = '0;
                farmed_next = 1'b1;
                if (cfg.invite_mode) begin
                  rarmed_next = 1'b0;
                  rleft_next  = '0;
                  fleft_next  = TIMER_BITS'(cfg.invite_expiry);
                end else begin
                  rleft_next  = TIMER_BITS'(cfg.retry_max);
                  rarmed_next = 1'b1;
                  fleft_next  = TIMER_BITS'(cfg.req_timeout);
                end
              end
            end else begin
              if (cfg.invite_mode) begin
                send = SEND_ACK;
              end
              if (cfg.invite_mode && !req.link_ok) begin
                term = 1'b1;
              end else begin
                pass        = (phase < PH_COMPLETED);
                phase_next  = PH_COMPLETED;
                fin         = 1'b1;
                rarmed_next = 1'b0;
                rleft_next  = '0;
                fleft_next  = cfg.invite_mode ? TIMER_BITS'(cfg.ack_wait)
                                              : TIMER_BITS'(cfg.cleanup);
                farmed_next = 1'b1;
              end
            end
          end
        end
      end
      OP_TICK: begin
        if (live) begin
          if (finish_armed) begin
            fleft_next = cfire ? '0 : finish_left - TIMER_BITS'(1);
          end
          if (retry_armed) begin
            rleft_next = rfire ? '0 : retry_left - TIMER_BITS'(1);
          end
          // Completion expiry wins over a retry due on the same tick
          if (cfire) begin
            term    = 1'b1;
            term_to = (phase == PH_COMPLETED) ? PH_SUCCESS : PH_TIMEOUT;
          end else if (rfire) begin
            rarmed_next = 1'b0;
            count_next  = count_sat;
            if (count_sat >= cfg.max_retries) begin
              term    = 1'b1;
              term_to = PH_RETRIES;
            end else begin
              send = (phase == PH_CANCELLING) ? SEND_CANCEL : SEND_REQUEST;
              if (!req.link_ok) begin
                term = 1'b1;
              end else begin
                rleft_next  = TIMER_BITS'(iv_reg);
                rarmed_next = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase

    // Terminal entry: stop both timers and release the waiter
    if (term) begin
      phase_next  = term_to;
      rarmed_next = 1'b0;
      rleft_next  = '0;
      farmed_next = 1'b0;
      fleft_next  = '0;
      fin         = 1'b1;
    end

    res.txn_state      = phase_next;
    res.send_kind      = send;
    res.pass_response  = pass;
    res.report_failure = term && (term_to != PH_SUCCESS);
    res.finished       = fin;
    res.refused        = refuse;
    res.retries_done   = count_next;
  end

  // Commit state on each executed request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      retry_count  <= '0;
      retry_left   <= '0;
      retry_armed  <= 1'b0;
      finish_left  <= '0;
      finish_armed <= 1'b0;
    end else if (exec) begin
      phase        <= phase_next;
      retry_count  <= count_next;
      retry_left   <= rleft_next;
      retry_armed  <= rarmed_next;
      finish_left  <= fleft_next;
      finish_armed <= farmed_next;
    end
  end

endmodule

### hw/rtl/sip_tre_checker.sv
// Port-level checks of the retry engine and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sip_tre_port_checker import sip_tre_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [3:0]         txn_state,
  input logic [1:0]         send_kind,
  input logic               pass_response,
  input logic               report_failure,
  input logic               finished,
  input logic               refused,
  input logic [RETRY_W-1:0] retries_done
);

  // Queues come out of reset empty
  `CHK_ASSERT_NR(a_rst_empty, clk, rst |=> (empty && !full))

  // A waiting result holds until taken
  `CHK_ASSERT(a_res_hold, clk, rst, (!empty && !pop) |=> ($stable(txn_state) && $stable(send_kind) && $stable(retries_done) && $stable(finished)))

  // A failure always releases the waiter
  `CHK_ASSERT(a_fail_fin, clk, rst, (!empty && report_failure) |-> finished)

  // A release without failure ends in completed or success
  `CHK_ASSERT(a_fin_ok, clk, rst, (!empty && finished && !report_failure) |-> (txn_state == PH_SUCCESS || txn_state == PH_COMPLETED))

  // A refused request sends nothing and hands nothing on
  `CHK_ASSERT(a_refuse_quiet, clk, rst, (!empty && refused) |-> (send_kind == SEND_NONE && !pass_response && !finished))

endmodule

bind sip_transaction_retry_engine_top sip_tre_port_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .txn_state      (txn_state),
  .send_kind      (send_kind),
  .pass_response  (pass_response),
  .report_failure (report_failure),
  .finished       (finished),
  .refused        (refused),
  .retries_done   (retries_done)
);
